@@ src/assert_macros.svh @@
// assertion macros shared by the fifo modules
// each module that asserts supplies clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge once reset is released
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, also during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/cfs_pkg.sv @@
// shared types and constants of the circular fifo with search
// no dependencies
package cfs_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ENQ    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;   // latch request, read slot at head
    logic step;     // search: advance to next slot
    logic finish;   // commit request and load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_done;  // request can complete this cycle
    logic out_free; // result register free or being drained
  } stat_t;

endpackage

@@ src/cfs_ctrl.sv @@
// controller state machine of the circular fifo with search
// depends on cfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module cfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cfs_pkg::stat_t stat,
  output cfs_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op_done) begin
          if (stat.out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_CLK(a_finish_when_done, cmd.finish |-> (stat.op_done && stat.out_free), "finish before done")
  `ASSERT_CLK(a_accept_then_exec, cmd.accept |=> (state_r == S_EXEC), "accept did not start exec")
  `ASSERT_ALWAYS(a_no_finish_idle, !(cmd.finish && (state_r == S_IDLE)), "finish in idle")

endmodule

@@ src/cfs_dp.sv @@
// datapath of the circular fifo with search: slot memory, pointers,
// capacity register, search scan and result register; depends on cfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module cfs_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [cfs_pkg::CAP_W-1:0]          cfg_wr_data,
  input  logic [cfs_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [cfs_pkg::DATA_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cfs_pkg::STAT_W-1:0]         out_status,
  output logic signed [cfs_pkg::DATA_W-1:0]  out_data_out,
  output logic [cfs_pkg::PTR_W-1:0]          out_found_slot,
  output logic [cfs_pkg::CNT_W-1:0]          out_fill_count,
  input  cfs_pkg::cmd_t                      cmd,
  output cfs_pkg::stat_t                     stat
);

  localparam int PW = cfs_pkg::PTR_W;
  localparam int CW = cfs_pkg::CNT_W;
  localparam int DW = cfs_pkg::DATA_W;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p,
                                             input logic [CW-1:0] cap);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    return (n >= cap) ? '0 : n[PW-1:0];
  endfunction

  logic signed [DW-1:0] slots_r [cfs_pkg::DEPTH];
  logic signed [DW-1:0] rdata_r;
  logic signed [DW-1:0] key_r;
  logic [cfs_pkg::KIND_W-1:0] kind_r;
  logic [cfs_pkg::CAP_W-1:0] cap_r;
  logic [PW-1:0] head_r, tail_r, scan_ptr_r, cmp_ptr_r;
  logic [CW-1:0] count_r, idx_r;
  logic [CW-1:0] cap_eff;
  logic [PW-1:0] rd_addr;
  logic rd_en, wr_en, hit;

  logic [PW-1:0] head_nxt, tail_nxt;
  logic [CW-1:0] count_nxt;
  logic [cfs_pkg::STAT_W-1:0] status_nxt;
  logic signed [DW-1:0] data_nxt;
  logic [PW-1:0] slot_nxt;

  logic out_valid_r;
  logic [cfs_pkg::STAT_W-1:0] out_status_r;
  logic signed [DW-1:0] out_data_r;
  logic [PW-1:0] out_slot_r;
  logic [CW-1:0] out_count_r;

  // zero acts as one, beyond depth acts as depth
  always_comb begin
    priority if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (CW'(cap_r) > CW'(cfs_pkg::DEPTH)) begin
      cap_eff = CW'(cfs_pkg::DEPTH);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  assign rd_en   = cmd.accept | cmd.step;
  assign rd_addr = cmd.accept ? head_r : scan_ptr_r;
  assign hit     = (idx_r < count_r) && (rdata_r == key_r);

  assign stat.op_done  = (kind_r != cfs_pkg::KIND_SEARCH) || hit || (idx_r >= count_r);
  assign stat.out_free = !out_valid_r || !out_stall;

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[tail_r] <= key_r;
    end
    if (rd_en) begin
      rdata_r    <= slots_r[rd_addr];
      cmp_ptr_r  <= rd_addr;
      scan_ptr_r <= ptr_next(rd_addr, cap_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      key_r  <= in_value;
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    status_nxt = cfs_pkg::ST_OK;
    data_nxt   = '0;
    slot_nxt   = '0;
    wr_en      = 1'b0;
    unique case (kind_r)
      cfs_pkg::KIND_ENQ: begin
        if (count_r >= cap_eff) begin
          status_nxt = cfs_pkg::ST_FULL;
        end else begin
          wr_en     = cmd.finish;
          tail_nxt  = ptr_next(tail_r, cap_eff);
          count_nxt = count_r + CW'(1);
        end
      end
      cfs_pkg::KIND_DEQ: begin
        if (count_r == '0) begin
          status_nxt = cfs_pkg::ST_EMPTY;
        end else begin
          data_nxt  = rdata_r;
          head_nxt  = ptr_next(head_r, cap_eff);
          count_nxt = count_r - CW'(1);
        end
      end
      cfs_pkg::KIND_PEEK: begin
        if (count_r == '0) begin
          status_nxt = cfs_pkg::ST_EMPTY;
        end else begin
          data_nxt = rdata_r;
        end
      end
      cfs_pkg::KIND_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
      cfs_pkg::KIND_SEARCH: begin
        if (hit) begin
          slot_nxt = cmp_ptr_r;
        end else begin
          status_nxt = cfs_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= cfs_pkg::CAP_W'(cfs_pkg::DEPTH);
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cfg_wr_en) begin
      cap_r   <= cfg_wr_data;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.finish) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status_nxt;
      out_data_r   <= data_nxt;
      out_slot_r   <= slot_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_out   = out_data_r;
  assign out_found_slot = out_slot_r;
  assign out_fill_count = out_count_r;

  `ASSERT_CLK(a_count_le_cap, count_r <= cap_eff, "entry count above capacity")
  `ASSERT_CLK(a_ptrs_in_range, (CW'(head_r) < cap_eff) && (CW'(tail_r) < cap_eff), "pointer beyond wrap point")
  `ASSERT_CLK(a_out_from_finish, $rose(out_valid_r) |-> $past(cmd.finish), "result without finish")

endmodule

@@ src/circular_fifo_with_search_unit.sv @@
// top level of the circular fifo with search
// instantiates cfs_ctrl and cfs_dp, types from cfs_pkg

// Ring-buffer fifo of signed 32-bit words with a 16-slot store. Each request
// (enqueue, dequeue, peek, clear, search) gives exactly one result with a
// status, a data word, a found slot and the fill count after the request.
// The capacity register (1 to 16, 0 acts as 1, above 16 acts as 16) sets the
// wrap point of the pointers; writing it also empties the fifo. The user must
// see that it is written only while the block is idle; the block does not
// enforce this. Enqueue, dequeue, peek, clear and the unused kinds need no
// scan. A search compares entries from the head up to the first match, or
// all entries when there is no match: the single registered read port of
// the slot memory delivers one entry per cycle to the key compare. The
// result sits in an output register, so a new request is taken while a
// result still waits; a request only holds at its final cycle if the
// previous result has not been taken yet.
module circular_fifo_with_search_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [cfs_pkg::CAP_W-1:0]          cfg_wr_data,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cfs_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [cfs_pkg::DATA_W-1:0]  in_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cfs_pkg::STAT_W-1:0]         out_status,
  output logic signed [cfs_pkg::DATA_W-1:0]  out_data_out,
  output logic [cfs_pkg::PTR_W-1:0]          out_found_slot,
  output logic [cfs_pkg::CNT_W-1:0]          out_fill_count
);

  // command and status between controller and datapath
  cfs_pkg::cmd_t  cmd;
  cfs_pkg::stat_t stat;

  // controller: idle waits for a request transfer, exec runs the search
  // scan and commits once the result register can take the result
  cfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: slot memory, head/tail/count, capacity and result register
  cfs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_found_slot (out_found_slot),
    .out_fill_count (out_fill_count),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule
